[src/cswpd_pkg.sv]
// Package for the CSW pulse decoder: constants and the command and status
// structs shared by the controller and the datapath. No dependencies.
package cswpd_pkg;

  localparam int unsigned TickRate  = 3500000;
  localparam int unsigned DivBits   = 54;
  localparam int unsigned CntBits   = $clog2(DivBits);
  localparam int unsigned ChunkBits = 22;

  localparam logic [31:0] SampleRateReset = 32'd44100;
  localparam logic [32:0] ChunkMax        = 33'h0_FFFF_FFFF;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic sum;
    logic fix;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pulse;
    logic premature;
    logic div_last;
  } dp_status_t;

endpackage

[src/cswpd_datapath.sv]
// Datapath of the CSW pulse decoder: escape parser, tick multiply, bit-serial
// division, chunk split and output registers. Depends on cswpd_pkg.
module cswpd_datapath import cswpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic [31:0]          sample_rate_i,
  input  logic                 initial_level_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 block_first_i,
  input  logic                 block_last_i,
  output logic [ChunkBits-1:0] full_chunks_o,
  output logic [31:0]          final_duration_o,
  output logic                 pulse_level_o,
  output logic                 premature_end_o,
  output logic [31:0]          pulses_so_far_o
);

  logic [2:0]  esc_phase_q, esc_phase_d;
  logic [31:0] long_q, long_d;
  logic        level_q, level_d;
  logic [31:0] total_q, total_d;

  logic [31:0] samples_q;
  logic        pend_level_q;
  logic        pend_prem_q;
  logic [31:0] pend_total_q;

  logic [31:0]        div_q;
  logic [DivBits-1:0] quo_q;
  logic [31:0]        rem_q;
  logic [CntBits-1:0] cnt_q;

  logic                 zero_q;
  logic [ChunkBits-1:0] hi_q;
  logic [32:0]          sum_q;
  logic [ChunkBits-1:0] res_chunks_q;
  logic [31:0]          res_fin_q;

  logic        eff_level;
  logic [2:0]  eff_phase;
  logic [31:0] eff_long;
  logic [31:0] eff_total;
  logic [1:0]  byte_idx;
  logic [31:0] long_new;
  logic [2:0]  phase_new;
  logic        pulse;
  logic        premature;
  logic [31:0] samples;

  always_comb begin
    eff_phase = block_first_i ? 3'd0 : esc_phase_q;
    eff_long  = block_first_i ? 32'd0 : long_q;
    eff_total = block_first_i ? 32'd0 : total_q;
    eff_level = block_first_i ? initial_level_i : level_q;
    byte_idx  = 2'(3'd4 - eff_phase);
    long_new  = eff_long | (32'(data_byte_i) << {byte_idx, 3'b000});
    pulse     = 1'b0;
    samples   = 32'(data_byte_i);
    phase_new = eff_phase;
    long_d    = eff_long;
    if (eff_phase == 3'd0) begin
      if (data_byte_i != 8'd0) begin
        pulse = 1'b1;
      end else begin
        phase_new = 3'd4;
        long_d    = 32'd0;
      end
    end else begin
      phase_new = eff_phase - 3'd1;
      long_d    = long_new;
      samples   = long_new;
      pulse     = (phase_new == 3'd0);
    end
    premature   = block_last_i && (phase_new != 3'd0);
    esc_phase_d = premature ? 3'd0 : phase_new;
    if (premature) begin
      long_d = 32'd0;
    end
    level_d = pulse ? ~eff_level : eff_level;
    total_d = pulse ? eff_total + 32'd1 : eff_total;
  end

  assign status_o.pulse     = pulse;
  assign status_o.premature = premature;
  assign status_o.div_last  = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_phase_q <= 3'd0;
      long_q      <= 32'd0;
      level_q     <= 1'b0;
      total_q     <= 32'd0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.accept) begin
        esc_phase_q <= esc_phase_d;
        long_q      <= long_d;
        level_q     <= level_d;
        total_q     <= total_d;
      end
      if (cmd_i.mul) begin
        cnt_q <= CntBits'(DivBits - 1);
      end else if (cmd_i.div_step && cnt_q != '0) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

  logic [32:0] trial;
  logic        ge;
  logic [DivBits-1:0] ticks_m1;
  logic [32:0] sum_red;

  assign trial    = {rem_q, quo_q[DivBits-1]};
  assign ge       = trial >= {1'b0, div_q};
  assign ticks_m1 = quo_q - DivBits'(1);
  assign sum_red  = sum_q - ChunkMax;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      samples_q    <= samples;
      pend_level_q <= eff_level;
      pend_prem_q  <= premature;
      pend_total_q <= total_d;
    end
    if (cmd_i.mul) begin
      quo_q <= DivBits'(samples_q) * DivBits'(TickRate);
      rem_q <= 32'd0;
      div_q <= (sample_rate_i == 32'd0) ? 32'd1 : sample_rate_i;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DivBits-2:0], ge};
      rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
    end
    if (cmd_i.sum) begin
      zero_q <= (quo_q == '0);
      hi_q   <= ticks_m1[DivBits-1:32];
      sum_q  <= 33'(ticks_m1[DivBits-1:32]) + 33'(ticks_m1[31:0]);
    end
    if (cmd_i.fix) begin
      if (zero_q) begin
        res_chunks_q <= '0;
        res_fin_q    <= 32'd0;
      end else if (sum_q >= ChunkMax) begin
        res_chunks_q <= hi_q + ChunkBits'(1);
        res_fin_q    <= sum_red[31:0] + 32'd1;
      end else begin
        res_chunks_q <= hi_q;
        res_fin_q    <= sum_q[31:0] + 32'd1;
      end
    end
    if (cmd_i.load_out) begin
      full_chunks_o    <= pend_prem_q ? '0 : res_chunks_q;
      final_duration_o <= pend_prem_q ? 32'd0 : res_fin_q;
      pulse_level_o    <= pend_level_q;
      premature_end_o  <= pend_prem_q;
      pulses_so_far_o  <= pend_total_q;
    end
  end

endmodule

[src/cswpd_ctrl.sv]
// Controller of the CSW pulse decoder: sequences accept, multiply, division,
// chunk split and output beat. Depends on cswpd_pkg.
module cswpd_ctrl import cswpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StSum  = 3'd3;
  localparam logic [2:0] StFix  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.pulse) begin
          state_d = StMul;
        end else if (in_valid_i && status_i.premature) begin
          state_d = StOut;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StSum;
        end
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StFix;
      end
      StFix: begin
        cmd_o.fix = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_excl_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> !(status_i.pulse && status_i.premature))
    else $error("pulse and premature end flagged for one beat");

  a_pulse_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.pulse) |=> (state_q == StMul))
    else $error("pulse beat did not start the multiply");

  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |=> (state_q == StDiv && !status_i.div_last))
    else $error("division not started after multiply");

  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !out_valid_q) |=> (out_valid_q && state_q == StIdle))
    else $error("result not loaded into a free output register");

endmodule

[src/csw_pulse_decoder_core.sv]
// Top level of the CSW pulse decoder: configuration registers and the
// controller and datapath. Depends on cswpd_pkg, cswpd_ctrl, cswpd_datapath.
//
// Each input beat is one byte of a CSW pulse data block. A byte that adds no
// result (an escape byte) is taken without stalling the input. A premature end
// is loaded into the output register from the output state, which follows the
// accepting idle state. A byte that completes a pulse is loaded into the output
// register after the multiply, the 54-step bit-serial division of the 54-bit
// tick product by the sample rate, the chunk split and the correction. The
// input is stalled until the result sits in the output register, so the next
// byte can be taken only after that. A stalled output beat holds the block for
// as long as the stall lasts.
module csw_pulse_decoder_core import cswpd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 block_first_i,
  input  logic                 block_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ChunkBits-1:0] full_chunks_o,
  output logic [31:0]          final_duration_o,
  output logic                 pulse_level_o,
  output logic                 premature_end_o,
  output logic [31:0]          pulses_so_far_o
);

  localparam logic RegSampleRate = 1'b0;
  localparam logic RegInitLevel  = 1'b1;

  logic [31:0] sample_rate_q;
  logic        initial_level_q;
  logic        cfg_write;
  ctrl_cmd_t   cmd;
  dp_status_t  status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q   <= SampleRateReset;
      initial_level_q <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[2])
        RegSampleRate: sample_rate_q   <= pwdata;
        RegInitLevel:  initial_level_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegSampleRate: prdata = sample_rate_q;
      RegInitLevel:  prdata = {31'd0, initial_level_q};
      default:       prdata = 32'd0;
    endcase
  end

  cswpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cswpd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_rate_i    (sample_rate_q),
    .initial_level_i  (initial_level_q),
    .data_byte_i      (data_byte_i),
    .block_first_i    (block_first_i),
    .block_last_i     (block_last_i),
    .full_chunks_o    (full_chunks_o),
    .final_duration_o (final_duration_o),
    .pulse_level_o    (pulse_level_o),
    .premature_end_o  (premature_end_o),
    .pulses_so_far_o  (pulses_so_far_o)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for csw_pulse_decoder_core: drives CSW data bytes and the APB
// registers, predicts each pulse result in step with the accepted beats and checks them.
// Depends on cswpd_pkg and the decoder RTL.
module tb import cswpd_pkg::*;;

  localparam logic [2:0]  RegSampleRate = 3'd0;
  localparam logic [2:0]  RegInitLevel  = 3'd4;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned StuckLimit    = 4000;
  localparam int unsigned HoldOffCycles = 400;
  localparam logic [63:0] TicksPerSec   = 64'd3500000;
  localparam logic [63:0] ChunkTicks    = 64'hFFFF_FFFF;

  typedef struct {
    logic [ChunkBits-1:0] chunks;
    logic [31:0]          fin;
    logic                 level;
    logic                 premature;
    logic [31:0]          count;
  } pulse_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i;
  logic                 block_first_i;
  logic                 block_last_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ChunkBits-1:0] full_chunks_o;
  logic [31:0]          final_duration_o;
  logic                 pulse_level_o;
  logic                 premature_end_o;
  logic [31:0]          pulses_so_far_o;

  logic [31:0] rate_reg       = SampleRateReset;
  logic        init_level_reg = 1'b0;
  logic [2:0]  esc_left       = 3'd0;
  logic [31:0] esc_count      = 32'd0;
  logic        level_q        = 1'b0;
  logic [31:0] pulse_cnt      = 32'd0;

  pulse_t      expected_pulses[$];
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_cycles  = 0;
  bit          idle_on      = 1'b1;

  csw_pulse_decoder_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .block_first_i    (block_first_i),
    .block_last_i     (block_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .full_chunks_o    (full_chunks_o),
    .final_duration_o (final_duration_o),
    .pulse_level_o    (pulse_level_o),
    .premature_end_o  (premature_end_o),
    .pulses_so_far_o  (pulses_so_far_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  function automatic void push_pulse(input logic [31:0] samples);
    logic [63:0] ticks;
    logic [63:0] chunks;
    logic [63:0] fin;
    pulse_t      p;
    ticks  = (TicksPerSec * {32'd0, samples}) / ((rate_reg == 32'd0) ? 64'd1 : {32'd0, rate_reg});
    chunks = 64'd0;
    fin    = 64'd0;
    if (ticks != 64'd0) begin
      chunks = (ticks - 64'd1) / ChunkTicks;
      fin    = ticks - chunks * ChunkTicks;
    end
    pulse_cnt   = pulse_cnt + 32'd1;
    p.chunks    = chunks[ChunkBits-1:0];
    p.fin       = fin[31:0];
    p.level     = level_q;
    p.premature = 1'b0;
    p.count     = pulse_cnt;
    expected_pulses.push_back(p);
    level_q = ~level_q;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic first_b,
                                      input logic last_b);
    pulse_t p;
    if (first_b) begin
      esc_left  = 3'd0;
      esc_count = 32'd0;
      pulse_cnt = 32'd0;
      level_q   = init_level_reg;
    end
    if (esc_left == 3'd0) begin
      if (b != 8'd0) begin
        push_pulse({24'd0, b});
      end else begin
        esc_left  = 3'd4;
        esc_count = 32'd0;
      end
    end else begin
      esc_count = esc_count | ({24'd0, b} << ((4 - esc_left) * 8));
      esc_left  = esc_left - 3'd1;
      if (esc_left == 3'd0) begin
        push_pulse(esc_count);
      end
    end
    if (last_b && esc_left != 3'd0) begin
      p.chunks    = '0;
      p.fin       = 32'd0;
      p.level     = level_q;
      p.premature = 1'b1;
      p.count     = pulse_cnt;
      expected_pulses.push_back(p);
      esc_left  = 3'd0;
      esc_count = 32'd0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first_b, input logic last_b);
    if (idle_on && $urandom_range(99) < 8) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    block_first_i <= first_b;
    block_last_i  <= last_b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, first_b, last_b);
    items_sent++;
  endtask

  task automatic send_escape(input logic [31:0] samples, input logic first_b,
                             input logic last_b);
    send_byte(8'd0, first_b, 1'b0);
    for (int k = 0; k < 4; k++) begin
      send_byte(samples[8*k +: 8], 1'b0, last_b && k == 3);
    end
  endtask

  task automatic reg_access(input logic write, input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (!write && prdata !== data) begin
      report_mismatch($sformatf("register %0d read %h, written %h", addr, prdata, data));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pulses.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] rate, input logic level);
    settle();
    reg_access(1'b1, RegSampleRate, rate);
    reg_access(1'b1, RegInitLevel, {31'd0, level});
    rate_reg       = rate;
    init_level_reg = level;
    reg_access(1'b0, RegSampleRate, rate);
    reg_access(1'b0, RegInitLevel, {31'd0, level});
  endtask

  // A block is a run of pulses; some lack the opening flag and some are cut off mid-escape.
  task automatic random_block();
    int unsigned n_pulses;
    int unsigned n_len;
    bit          opening;
    bit          truncate;
    bit          closing;
    logic [31:0] samples;
    n_pulses = $urandom_range(1, 8);
    opening  = $urandom_range(9) != 0;
    truncate = $urandom_range(9) == 0;
    for (int i = 0; i < n_pulses; i++) begin
      closing = !truncate && i == n_pulses - 1;
      if ($urandom_range(3) != 0) begin
        send_byte(8'($urandom_range(1, 255)), opening && i == 0, closing);
      end else begin
        case ($urandom_range(3))
          0: samples = $urandom;
          1: samples = $urandom_range(0, 255);
          2: samples = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
          default: samples = $urandom_range(256, 100000);
        endcase
        send_escape(samples, opening && i == 0, closing);
      end
    end
    if (truncate) begin
      n_len = $urandom_range(3);
      send_byte(8'd0, 1'b0, n_len == 0);
      for (int j = 0; j < n_len; j++) begin
        send_byte(8'($urandom), 1'b0, j == n_len - 1);
      end
    end
  endtask

  task automatic random_stream(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) != 0) begin
        random_block();
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0);
        end
      end
    end
  endtask

  task automatic test_directed_pulses();
    set_config(32'd44100, 1'b0);
    send_byte(8'd1, 1'b1, 1'b0);
    send_byte(8'd255, 1'b0, 1'b0);
    send_escape(32'h1234_5678, 1'b0, 1'b0);
    send_escape(32'd0, 1'b0, 1'b1);
  endtask

  task automatic test_premature_end();
    set_config(32'd44100, 1'b1);
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b1);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd1, 1'b0, 1'b0);
    send_byte(8'd2, 1'b0, 1'b1);
    // Decoding carries on without a fresh block start.
    send_byte(8'd5, 1'b0, 1'b0);
    // A block start in the middle of an escape abandons it.
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'd9, 1'b1, 1'b1);
  endtask

  task automatic test_rate_extremes();
    set_config(32'd1, 1'b1);
    send_escape(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_byte(8'd255, 1'b0, 1'b1);
    set_config(32'd0, 1'b0);
    send_byte(8'd255, 1'b1, 1'b1);
    set_config(32'hFFFF_FFFF, 1'b1);
    send_escape(32'hFFFF_FFFF, 1'b1, 1'b1);
  endtask

  task automatic test_random_rates();
    logic [31:0] rate;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: rate = 32'd22050;
        1: rate = 32'd1;
        2: rate = 32'd0;
        3: rate = 32'hFFFF_FFFF;
        4: rate = $urandom_range(8000, 192000);
        default: rate = $urandom;
      endcase
      set_config(rate, ph % 2 == 1);
      random_stream(250);
    end
  endtask

  task automatic test_backpressure();
    set_config(32'd44100, 1'b0);
    hold_cycles = HoldOffCycles;
    random_stream(40);
  endtask

  task automatic test_no_idling();
    set_config(32'd48000, 1'($urandom_range(1)));
    idle_on = 1'b0;
    random_stream(300);
    idle_on = 1'b1;
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall_i <= idle_on && $urandom_range(99) < 8;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    pulse_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pulses.size() == 0) begin
        report_mismatch("result beat with no pulse expected");
      end else begin
        want = expected_pulses.pop_front();
        if (full_chunks_o !== want.chunks) begin
          report_mismatch($sformatf("full_chunks %0d, expected %0d", full_chunks_o, want.chunks));
        end
        if (final_duration_o !== want.fin) begin
          report_mismatch($sformatf("final_duration %0d, expected %0d",
                                    final_duration_o, want.fin));
        end
        if (pulse_level_o !== want.level) begin
          report_mismatch($sformatf("pulse_level %b, expected %b", pulse_level_o, want.level));
        end
        if (premature_end_o !== want.premature) begin
          report_mismatch($sformatf("premature_end %b, expected %b",
                                    premature_end_o, want.premature));
        end
        if (pulses_so_far_o !== want.count) begin
          report_mismatch($sformatf("pulses_so_far %0d, expected %0d",
                                    pulses_so_far_o, want.count));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("Timeout: no beat moved for %0d cycles", StuckLimit);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    block_first_i = 1'b0;
    block_last_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_pulses();
    test_premature_end();
    test_rate_extremes();
    test_random_rates();
    test_backpressure();
    test_no_idling();
    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
